// ===== hdl/prm_pkg.sv =====
// Package for the pulse rate meter: widths, request codes, register indexes, divider bundles.
`timescale 1ns / 1ps

package prm_pkg;

  // Default modulus of the external pulse counter
  localparam int unsigned COUNTER_WRAP_DEF = 32767;

  // Field widths
  localparam int unsigned CNT_W     = 15;
  localparam int unsigned TIME_W    = 63;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned PPR_W     = 16;
  localparam int unsigned IVL_W     = 32;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned OUT_USER_W = 2;

  // Shared divider: quotient/dividend and divisor widths, iteration counter
  localparam int unsigned QW     = 53;
  localparam int unsigned DVS_W  = 63;
  localparam int unsigned ITER_W = 6;
  localparam int unsigned MOD_W  = 32;
  localparam int unsigned PROD_W = 37;

  // Rate scale: 1e6 us per second, times 2^16 for Q16.16 (applied as a shift)
  localparam logic [PROD_W-1:0] US_PER_SEC = PROD_W'(1000000);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TOTAL  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;

  // Register reset values
  localparam logic [PPR_W-1:0] PPR_RESET      = 16'd1;
  localparam logic [IVL_W-1:0] INTERVAL_RESET = 32'd60000000;

  typedef struct packed {
    logic              start;
    logic [QW-1:0]     dividend;  // left aligned: top nbits bits are used
    logic [DVS_W-1:0]  divisor;
    logic [ITER_W-1:0] nbits;
  } prm_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QW-1:0]    quo;
  } prm_div_rsp_t;

endpackage

// ===== hdl/prm_div.sv =====
// Bit-serial restoring divider shared by both rate divisions.
`timescale 1ns / 1ps

module prm_div
  import prm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  prm_div_req_t req,
  output prm_div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [QW-1:0]     q_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    shifted;
  logic              ge;
  logic [DVS_W:0]    diff;

  // One quotient bit per cycle
  assign shifted = {rem_r, q_r[QW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
        q_r    <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[QW-2:0], ge};
        rem_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

// ===== hdl/pulse_rate_meter_top.sv =====
// Top level of the pulse rate meter: sequencer, state, registers and result buffer.
//
//  channel | direction | payload
//  --------+-----------+------------------------------------------------------------
//  in_     | slave     | tuser: req_type; tdata: counter_value, time_us, new_total
//  out_    | master    | tuser: rate_valid, persist_now; tdata: delta, rate, total
//  cfg_    | slave     | cfg_index (0 pulses_per_rev, 1 persist_interval_us), cfg_data
//
// One item at a time. A sample with positive elapsed time first takes the counter
// modulo as a reciprocal multiply and then a multiply-subtract, then the shared
// bit-serial divider does pulses*1e6*2^16 by elapsed time (53 quotient bits)
// and that quotient by pulses_per_rev (53 quotient bits).
// No elapsed time: the divider is skipped; start and set-total skip all arithmetic.
// in_tready is high only while the sequencer is idle. A finished result sits in the
// output register, so the next transaction is taken while out_tready is low; the
// block stalls only if a second result is ready before the first is taken.
// Reset (rst_n low, synchronous) clears control/meter state; registers to defaults.
// cfg_ready is always high; writes are meant for idle periods.
`timescale 1ns / 1ps

module pulse_rate_meter_top
  import prm_pkg::*;
#(
  parameter int unsigned COUNTER_WRAP = COUNTER_WRAP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transaction
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [14:0] counter_value, [77:15] time_us, [109:78] new_total, [111:110] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [REQ_W-1:0]      in_tuser,
  // result transaction
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [14:0] pulse_delta, [46:15] rate_q16, [78:47] total_count, [79] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] rate_valid, [1] persist_now
  output logic [OUT_USER_W-1:0] out_tuser,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [IVL_W-1:0]      cfg_data
);

  localparam int unsigned DELTA_W = $clog2(COUNTER_WRAP);

  // Reciprocal of the counter modulus: floor(x / m) = (x * MOD_MAGIC) >> MOD_SHIFT,
  // exact for every 32-bit x
  localparam int unsigned MOD_SHIFT  = MOD_W + $clog2(COUNTER_WRAP);
  localparam int unsigned MAGIC_W    = MOD_W + 1;
  localparam int unsigned MOD_PROD_W = MOD_W + MAGIC_W;
  localparam logic [MAGIC_W-1:0] MOD_MAGIC =
    MAGIC_W'((64'd1 << MOD_SHIFT) / 64'(COUNTER_WRAP) + 64'd1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_PERS = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_REM  = 3'd7;

  logic [2:0]            state_r;

  // registers
  logic [PPR_W-1:0]      ppr_r;
  logic [IVL_W-1:0]      interval_r;

  // meter state
  logic [CNT_W-1:0]      prev_r;
  logic [TIME_W-1:0]     last_sample_r;
  logic [TIME_W-1:0]     last_save_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [TOTAL_W-1:0]    saved_r;

  // per-item working registers
  logic [TIME_W-1:0]     t_r;
  logic [TIME_W-1:0]     elapsed_r;
  logic [MOD_W-1:0]      mod_x_r;
  logic [MOD_W-1:0]      mod_q_r;
  logic [DELTA_W-1:0]    delta_r;
  logic                  valid_r;
  logic                  save_ok_r;
  logic                  persist_r;
  logic [RATE_W-1:0]     rate_r;

  // result buffer
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  prm_div_req_t          div_req_r;
  prm_div_rsp_t          div_rsp;

  // unpacked input fields
  logic [CNT_W-1:0]      in_cnt;
  logic [TIME_W-1:0]     in_time;
  logic [TOTAL_W-1:0]    in_total;

  logic [MOD_W-1:0]      wrap_sum;
  logic [MOD_PROD_W-1:0] mod_prod;
  logic [MOD_W-1:0]      mod_q;
  logic [MOD_W-1:0]      mod_rem;
  logic [31:0]           delta32;
  logic [PROD_W-1:0]     prod;
  logic [PPR_W-1:0]      ppr_eff;
  logic [TOTAL_W-1:0]    total_nxt;
  logic [TIME_W-1:0]     since_save;
  logic                  out_free;

  assign in_cnt   = in_tdata[14:0];
  assign in_time  = in_tdata[77:15];
  assign in_total = in_tdata[109:78];

  // counter difference wraps mod 2^32 before the modulo, as the counter math does
  assign wrap_sum   = MOD_W'(in_cnt) + MOD_W'(COUNTER_WRAP) - MOD_W'(prev_r);
  // modulo: quotient by reciprocal, then remainder by multiply-subtract
  assign mod_prod   = MOD_PROD_W'(mod_x_r) * MOD_PROD_W'(MOD_MAGIC);
  assign mod_q      = MOD_W'(mod_prod >> MOD_SHIFT);
  assign mod_rem    = mod_x_r - mod_q_r * MOD_W'(COUNTER_WRAP);
  assign delta32    = 32'(delta_r);
  assign prod       = PROD_W'(delta_r) * US_PER_SEC;
  assign ppr_eff    = (ppr_r == '0) ? PPR_W'(1) : ppr_r;
  assign total_nxt  = total_r + delta32;
  assign since_save = t_r - last_save_r;
  assign out_free   = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  prm_div u_prm_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
      ppr_r           <= PPR_RESET;
      interval_r      <= INTERVAL_RESET;
      prev_r          <= '0;
      last_sample_r   <= '0;
      last_save_r     <= '0;
      total_r         <= '0;
      saved_r         <= '0;
    end else begin
      div_req_r.start <= 1'b0;

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          CFG_PPR:      ppr_r      <= cfg_data[PPR_W-1:0];
          CFG_INTERVAL: interval_r <= cfg_data;
          default:      ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            t_r       <= in_time;
            delta_r   <= '0;
            valid_r   <= 1'b0;
            rate_r    <= '0;
            persist_r <= 1'b0;
            state_r   <= S_FIN;
            case (in_tuser)
              REQ_START: begin
                prev_r        <= in_cnt;
                last_sample_r <= in_time;
                last_save_r   <= in_time;
                saved_r       <= total_r;
              end
              REQ_SAMPLE: begin
                mod_x_r       <= wrap_sum;
                prev_r        <= in_cnt;
                valid_r       <= in_time > last_sample_r;
                elapsed_r     <= in_time - last_sample_r;
                last_sample_r <= in_time;
                state_r       <= S_MOD;
              end
              REQ_TOTAL: begin
                total_r <= in_total;
              end
              default: ;
            endcase
          end
        end

        S_MOD: begin
          mod_q_r <= mod_q;
          state_r <= S_REM;
        end

        S_REM: begin
          delta_r <= mod_rem[DELTA_W-1:0];
          state_r <= S_MUL;
        end

        S_MUL: begin
          save_ok_r <= (t_r >= last_save_r) && (since_save >= TIME_W'(interval_r));
          if (valid_r) begin
            // pulses * 1e6 * 2^16 over elapsed microseconds
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= {prod, 16'b0};
            div_req_r.divisor  <= elapsed_r;
            div_req_r.nbits    <= ITER_W'(QW);
            state_r            <= S_DIV1;
          end else begin
            rate_r  <= '0;
            state_r <= S_PERS;
          end
        end

        S_DIV1: begin
          if (div_rsp.done) begin
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= div_rsp.quo;
            div_req_r.divisor  <= DVS_W'(ppr_eff);
            div_req_r.nbits    <= ITER_W'(QW);
            state_r            <= S_DIV2;
          end
        end

        S_DIV2: begin
          if (div_rsp.done) begin
            // saturate to Q16.16 max
            if (|div_rsp.quo[QW-1:RATE_W]) begin
              rate_r <= '1;
            end else begin
              rate_r <= div_rsp.quo[RATE_W-1:0];
            end
            state_r <= S_PERS;
          end
        end

        S_PERS: begin
          total_r <= total_nxt;
          if ((total_nxt != saved_r) && save_ok_r) begin
            persist_r   <= 1'b1;
            saved_r     <= total_nxt;
            last_save_r <= t_r;
          end
          state_r <= S_FIN;
        end

        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0, total_r, rate_r, delta32[CNT_W-1:0]};
            out_user_r  <= {persist_r, valid_r};
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/prm_checker.sv =====
// Port-level checker for the pulse rate meter, bound to the top level.
`timescale 1ns / 1ps

module prm_checker
  import prm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // one item at a time: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high in the cycle after an input transaction");

  // no rate without a valid elapsed time
  a_rate_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[46:15] == 32'd0)
    else $error("nonzero rate with rate_valid low");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed or dropped while stalled");

  // reset empties the result buffer
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind pulse_rate_meter_top prm_checker u_prm_checker (.*);
